// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define DCC_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the block's own clock and reset.
`define DCC_ASSERT(lbl, prop, msg) \
  `DCC_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/dcc_pkg.sv =====
package dcc_pkg;

  // time-of-day pipeline spans stages 6..14 of the core
  localparam int unsigned TOD_STAGES = 9;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

endpackage

// ===== design/day_count_to_calendar_date_core.sv =====
// Throughput: one word per cycle while the output is not stalled; every stage has its own valid bit, so
// bubbles close up under a stall and a stage moves whenever the one after it can.
// All division is by constants (reciprocal multiplies or shifts), at most one multiply per stage of the core.
// Reset clears the valid bits only; data registers are not reset.
`include "assert_macros.svh"

module day_count_to_calendar_date_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [38:0] seconds_since_epoch, [39] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [14:0] year_number, [18:15] month_number,
                                      // [23:19] day_of_month, [28:24] hour_of_day,
                                      // [34:29] minute_of_hour, [40:35] second_of_minute,
                                      // [49:41] approx_day_of_year, [55:50] zero
);

  localparam int unsigned NS = 14;

  // day number split: v/675 done as two 16/18-bit chunks on a biased value
  localparam logic [63:0] KCNT   = ((64'd1 << 32) + 64'd674) / 64'd675;
  localparam logic [63:0] KOFF_W = KCNT * 64'd675;
  localparam logic [33:0] KOFF   = KOFF_W[33:0];
  localparam logic [63:0] ZADJ_W = 64'd2451545 - KCNT;
  localparam logic [25:0] ZADJ   = ZADJ_W[25:0];

  localparam logic [63:0] M1_W = ((64'd1 << 28) + 64'd674) / 64'd675;
  localparam logic [18:0] M1   = M1_W[18:0];
  localparam logic [63:0] M2_W = ((64'd1 << 35) + 64'd674) / 64'd675;
  localparam logic [25:0] M2   = M2_W[25:0];
  localparam logic [63:0] MA_W = ((64'd1 << 42) + 64'd146096) / 64'd146097;
  localparam logic [24:0] MA   = MA_W[24:0];
  localparam logic [63:0] MC_W = ((64'd1 << 46) + 64'd36524) / 64'd36525;
  localparam logic [30:0] MC   = MC_W[30:0];
  localparam logic [63:0] ME_W = ((64'd10000 << 32) + 64'd306000) / 64'd306001;
  localparam logic [27:0] ME   = ME_W[27:0];
  localparam logic [63:0] MD_W = ((64'd1 << 16) + 64'd71) / 64'd72;
  localparam logic [9:0]  MD   = MD_W[9:0];

  // floor(30.6001 * e) for e = 4..15
  function automatic logic [8:0] month_base(input logic [3:0] e);
    logic [8:0] r;
    case (e)
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en[i] = m_axis_tready | ~(&(vld_q | ((NS'(1) << i) - NS'(1))));
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [39:0] x;
  logic [33:0] u1_q;
  logic [6:0]  lo1_q, lo2_q, lo3_q, lo4_q;
  logic [17:0] a2_q;
  logic [15:0] b2_q;
  logic [8:0]  q1_2_q, q1_3_q, q1_4_q;
  logic [25:0] t3_q, t4_q;
  logic [15:0] q2_4_q;
  logic [23:0] z5_q, z6_q, z7_q;
  logic [16:0] rx5_q;
  logic        greg6_q, greg7_q;
  logic [23:0] n6_q;
  logic [6:0]  alpha7_q;
  logic [29:0] nc8_q;
  logic [23:0] b8_q, b9_q;
  logic [14:0] cq9_q;
  logic [8:0]  bd10_q, bd11_q;
  logic [15:0] c10_q, c11_q;
  logic [3:0]  e11_q;
  logic [4:0]  day12_q, day13_q, day14_q;
  logic [3:0]  mon12_q, mon13_q, mon14_q;
  logic [15:0] yr12_q, yr13_q, yr14_q;
  logic [8:0]  k13_q;
  logic [8:0]  doy14_q;

  logic [36:0] p1;
  logic [17:0] q1m;
  logic [9:0]  r1;
  logic [51:0] p2;
  logic [25:0] q2m;
  logic [9:0]  r2;
  logic [25:0] zf;
  logic [25:0] nw;
  logic [48:0] pa;
  logic [23:0] zz;
  logic [31:0] b32;
  logic [31:0] nc32;
  logic [60:0] pc;
  logic [15:0] c10;
  logic [23:0] dd;
  logic [23:0] bdw;
  logic [36:0] pe;
  logic [8:0]  dayw;
  logic [3:0]  mon12;
  logic [15:0] yr12a;
  logic [15:0] yr12;
  logic [3:0]  mm1;
  logic [18:0] pd;

  assign x   = {s_axis_tdata[38], s_axis_tdata[38:0]} + 40'd43200;

  assign p1  = 37'(u1_q[33:16]) * 37'(M1);
  assign q1m = 18'(q1_2_q) * 18'd675;
  assign r1  = 10'(a2_q - q1m);

  assign p2  = 52'(t3_q) * 52'(M2);
  assign q2m = 26'(q2_4_q) * 26'd675;
  assign r2  = 10'(t4_q - q2m);
  assign zf  = {1'b0, q1_4_q, q2_4_q} + ZADJ;

  assign nw  = {z5_q, 2'b00} - 26'd7468865;

  assign pa  = 49'(n6_q) * 49'(MA);

  // Gregorian correction only from the switch day on
  assign zz   = greg7_q ? (z7_q + 24'd1 + 24'(alpha7_q) - 24'(alpha7_q[6:2])) : z7_q;
  assign b32  = 32'($signed(zz + 24'd1524));
  // 100*b - 12210, biased by 2048*36525 to stay positive
  assign nc32 = b32 * 32'd100 + 32'd74790990;

  assign pc  = 61'(nc8_q) * 61'(MC);

  assign c10 = {1'b0, cq9_q} - 16'd2048;
  assign dd  = 24'($signed(c10)) * 24'd365 + 24'($signed(c10) >>> 2);
  assign bdw = b9_q - dd;

  assign pe  = 37'(bd10_q) * 37'(ME);

  assign dayw  = bd11_q - month_base(e11_q);
  assign mon12 = (e11_q > 4'd13) ? (e11_q - 4'd13) : (e11_q - 4'd1);
  assign yr12a = c11_q - 16'd4715 - ((mon12 > 4'd2) ? 16'd1 : 16'd0);
  // no year zero
  assign yr12  = ($signed(yr12a) <= 16'sd0) ? (yr12a - 16'd1) : yr12a;

  assign mm1 = mon12_q - 4'd1;
  assign pd  = 19'(k13_q) * 19'(MD);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u1_q  <= {x[39], x[39:7]} + KOFF;
      lo1_q <= x[6:0];
    end
    if (en[1]) begin
      a2_q   <= u1_q[33:16];
      b2_q   <= u1_q[15:0];
      q1_2_q <= p1[36:28];
      lo2_q  <= lo1_q;
    end
    if (en[2]) begin
      t3_q   <= {r1, b2_q};
      q1_3_q <= q1_2_q;
      lo3_q  <= lo2_q;
    end
    if (en[3]) begin
      t4_q   <= t3_q;
      q2_4_q <= p2[50:35];
      q1_4_q <= q1_3_q;
      lo4_q  <= lo3_q;
    end
    if (en[4]) begin
      z5_q  <= zf[23:0];
      rx5_q <= {r2, lo4_q};
    end
    if (en[5]) begin
      greg6_q <= ($signed(z5_q) >= 24'sd2299161);
      n6_q    <= nw[23:0];
      z6_q    <= z5_q;
    end
    if (en[6]) begin
      alpha7_q <= pa[48:42];
      greg7_q  <= greg6_q;
      z7_q     <= z6_q;
    end
    if (en[7]) begin
      nc8_q <= nc32[29:0];
      b8_q  <= b32[23:0];
    end
    if (en[8]) begin
      cq9_q <= pc[60:46];
      b9_q  <= b8_q;
    end
    if (en[9]) begin
      bd10_q <= bdw[8:0];
      c10_q  <= c10;
    end
    if (en[10]) begin
      e11_q  <= pe[35:32];
      bd11_q <= bd10_q;
      c11_q  <= c10_q;
    end
    if (en[11]) begin
      day12_q <= dayw[4:0];
      mon12_q <= mon12;
      yr12_q  <= yr12;
    end
    if (en[12]) begin
      k13_q   <= 9'(mm1) * 9'd30 + 9'(day12_q);
      day13_q <= day12_q;
      mon13_q <= mon12_q;
      yr13_q  <= yr12_q;
    end
    if (en[13]) begin
      doy14_q <= k13_q + 9'(pd[18:16]);
      day14_q <= day13_q;
      mon14_q <= mon13_q;
      yr14_q  <= yr13_q;
    end
  end

  dcc_pkg::tod_t tod;

  dcc_tod u_tod (
    .clk_i (clk_i),
    .en_i  (en[NS-1:NS-dcc_pkg::TOD_STAGES]),
    .rx_i  (rx5_q),
    .tod_o (tod)
  );

  assign m_axis_tdata = {6'd0, doy14_q, tod.second, tod.minute, tod.hour,
                         day14_q, mon14_q, yr14_q[14:0]};

  // ---------------------------------------------------------------- checks
  logic date_ok, tod_ok, bd_ok;

  assign date_ok = (mon14_q != 4'd0) && (mon14_q <= 4'd12) && (day14_q != 5'd0);
  assign tod_ok  = (tod.hour < 5'd24) && (tod.minute < 6'd60) && (tod.second < 6'd60);
  assign bd_ok   = (bd10_q >= 9'd123) && (bd10_q <= 9'd488);

  `DCC_ASSERT(a_date_range, m_axis_tvalid |-> date_ok, "date field out of range")
  `DCC_ASSERT(a_tod_range, m_axis_tvalid |-> tod_ok, "time field out of range")
  `DCC_ASSERT(a_bd_range, vld_q[9] |-> bd_ok, "day-in-cycle out of range")
  `DCC_ASSERT(a_full_stall, (&vld_q) && !m_axis_tready |-> !s_axis_tready, "accept into full stall")

endmodule

// ===== design/dcc_tod.sv =====
// Splits the seconds within the day into hour, minute, second and
// delays them to line up with the date stages.
module dcc_tod (
  input  logic                               clk_i,
  input  logic [dcc_pkg::TOD_STAGES-1:0]     en_i,
  input  logic [16:0]                        rx_i,   // seconds after midnight, 0..86399
  output dcc_pkg::tod_t                      tod_o
);

  localparam int unsigned DLY = dcc_pkg::TOD_STAGES - 4;

  // reciprocals: exact for the operand ranges used
  localparam logic [63:0] MH_W = ((64'd1 << 29) + 64'd3599) / 64'd3600;
  localparam logic [17:0] MH   = MH_W[17:0];
  localparam logic [63:0] MM_W = ((64'd1 << 18) + 64'd59) / 64'd60;
  localparam logic [12:0] MM   = MM_W[12:0];

  logic [16:0] rx6_q;
  logic [4:0]  hour6_q, hour7_q, hour8_q;
  logic [11:0] m7_q, m8_q;
  logic [5:0]  minute8_q;
  dcc_pkg::tod_t tod9_q;
  dcc_pkg::tod_t dly_q [DLY];

  logic [34:0] ph;
  logic [16:0] hsec;
  logic [24:0] pm;
  logic [11:0] msec;
  logic [11:0] ssub;

  assign ph   = 35'(rx_i) * 35'(MH);
  assign hsec = 17'(hour6_q) * 17'd3600;
  assign pm   = 25'(m7_q) * 25'(MM);
  assign msec = 12'(minute8_q) * 12'd60;
  assign ssub = m8_q - msec;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rx6_q   <= rx_i;
      hour6_q <= ph[33:29];
    end
    if (en_i[1]) begin
      m7_q    <= 12'(rx6_q - hsec);
      hour7_q <= hour6_q;
    end
    if (en_i[2]) begin
      m8_q      <= m7_q;
      minute8_q <= pm[23:18];
      hour8_q   <= hour7_q;
    end
    if (en_i[3]) begin
      tod9_q.hour   <= hour8_q;
      tod9_q.minute <= minute8_q;
      tod9_q.second <= ssub[5:0];
    end
    if (en_i[4]) begin
      dly_q[0] <= tod9_q;
    end
    for (int j = 1; j < DLY; j++) begin
      if (en_i[4+j]) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  assign tod_o = dly_q[DLY-1];

endmodule
